// ----- src/taplm_pkg.sv -----
// ----------------------------------------------------------------------------
// taplm_pkg
// Shared types, constants and helpers of the all-prefix trie lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package taplm_pkg;

  localparam int NODE_COUNT  = 256;
  localparam int MAX_LEVELS  = 16;
  localparam int STRIDE_BITS = 8;
  localparam int SLOT_COUNT  = 1 << STRIDE_BITS;

  localparam int NODE_AW     = $clog2(NODE_COUNT);
  localparam int STORE_AW    = NODE_AW + STRIDE_BITS;
  localparam int STORE_DEPTH = NODE_COUNT * SLOT_COUNT;

  localparam int LEVEL_W     = 4;
  localparam int LEVEL_CNT_W = 5;

  localparam int CFG_DATA_W  = 32;
  localparam int HOP_W       = 32;
  localparam int CHILD_W     = 8;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_WRITE  = 1'b1
  } req_type_t;

  typedef enum logic {
    CFG_MAX_DEPTH   = 1'b0,
    CFG_DEFAULT_HOP = 1'b1
  } cfg_index_t;

  localparam logic [7:0] MAX_DEPTH_RESET = 8'd32;

  // byte 0 sits in the top bits of the high word, byte 8 in the top of the low word
  function automatic logic [7:0] addr_byte(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [LEVEL_W-1:0] level);
    logic [63:0] word;
    logic [2:0]  k;
    word = level[3] ? lo : hi;
    k    = ~level[2:0];
    return word[{k, 3'b000} +: 8];
  endfunction

  // levels walked: ceil(bits / 8), saturated
  function automatic logic [LEVEL_CNT_W-1:0] level_count(input logic [7:0] depth_bits);
    logic [8:0] sum;
    logic [5:0] lv;
    sum = {1'b0, depth_bits} + 9'd7;
    lv  = sum[8:3];
    return (lv > 6'(MAX_LEVELS)) ? LEVEL_CNT_W'(MAX_LEVELS) : lv[LEVEL_CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/taplm_ram.sv -----
// ----------------------------------------------------------------------------
// taplm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module taplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/trie_all_prefix_match_lookup_core.sv -----
// ----------------------------------------------------------------------------
// trie_all_prefix_match_lookup_core
// Multibit trie (8-bit stride) lookup that reports every matching prefix.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a write item sets one slot of a node
// and gives no result. A lookup walks the address one byte per level,
// shallowest first, and gives one result per valid nonzero hop, or one
// default / not-found result; out_last marks the final one.
// Throughput: one item at a time; the next item can transfer only once the
// lookup's last result is loaded. A walk that hits a missing child ends early.
// Each level is one read of the node store, whose child field addresses the
// next read, so the store's single read port sets the pace.
// A match is held back one step so that last can be set on the deepest.
// Output channel (out_valid / out_stall): results sit in an output register;
// a walk with a result to hand over waits while the receiver stalls, and
// in_stall stays high until the lookup's last result is loaded.
// Config channel (cfg_valid / cfg_ready): always ready, write only while idle.
// Reset: registers return to defaults, then a clearing pass over all
// NODE_COUNT * 256 entries (65536) zeroes child and valid marks; in_stall is
// high during the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_all_prefix_match_lookup_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [63:0] in_addr_hi,
  input  wire logic [63:0] in_addr_lo,
  input  wire logic [7:0]  in_node_sel,
  input  wire logic [7:0]  in_slot_sel,
  input  wire logic [7:0]  in_child_node,
  input  wire logic        in_slot_valid,
  input  wire logic [31:0] in_slot_hop,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic             out_from_default,
  output logic [3:0]       out_match_level,
  output logic [31:0]      out_next_hop,
  output logic             out_last,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t state_r;

  logic [taplm_pkg::STORE_AW-1:0]    clr_addr_r;
  logic [7:0]                        max_depth_r;
  logic [taplm_pkg::HOP_W-1:0]       default_hop_r;
  logic [63:0]                       addr_hi_r;
  logic [63:0]                       addr_lo_r;
  logic [taplm_pkg::LEVEL_W-1:0]     lvl_r;
  logic [taplm_pkg::LEVEL_CNT_W-1:0] levels_r;
  logic                              pend_vld_r;
  logic [taplm_pkg::LEVEL_W-1:0]     pend_lvl_r;
  logic [taplm_pkg::HOP_W-1:0]       pend_hop_r;

  logic                              out_valid_r;
  logic                              out_found_r;
  logic                              out_from_default_r;
  logic [taplm_pkg::LEVEL_W-1:0]     out_match_level_r;
  logic [taplm_pkg::HOP_W-1:0]       out_next_hop_r;
  logic                              out_last_r;

  // store ports
  logic                              cv_we;
  logic [taplm_pkg::STORE_AW-1:0]    cv_waddr;
  logic [taplm_pkg::CHILD_W:0]       cv_wdata;
  logic [taplm_pkg::CHILD_W:0]       cv_rdata;
  logic                              hop_we;
  logic [taplm_pkg::HOP_W-1:0]       hop_rdata;
  logic                              rd_en;
  logic [taplm_pkg::STORE_AW-1:0]    rd_addr;
  logic [taplm_pkg::STORE_AW-1:0]    wr_addr;

  logic                              in_xfer;
  logic                              wr_xfer;
  logic                              lk_xfer;
  logic                              node_ok;
  logic [taplm_pkg::LEVEL_CNT_W-1:0] lv_cnt;
  logic                              out_free;

  logic [taplm_pkg::CHILD_W-1:0]     rd_child;
  logic                              rd_valid;
  logic                              match;
  logic                              child_ok;
  logic                              walk_done;
  logic                              need_emit;
  logic                              walk_go;
  logic [taplm_pkg::LEVEL_W-1:0]     lvl_inc;
  logic                              out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign in_xfer  = in_valid && !in_stall;
  assign wr_xfer  = in_xfer && (in_req_type == taplm_pkg::REQ_WRITE);
  assign lk_xfer  = in_xfer && (in_req_type == taplm_pkg::REQ_LOOKUP);
  assign node_ok  = ({24'd0, in_node_sel} < 32'(taplm_pkg::NODE_COUNT));
  assign lv_cnt   = taplm_pkg::level_count(max_depth_r);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_addr  = {taplm_pkg::NODE_AW'(in_node_sel), in_slot_sel};

  assign rd_child  = cv_rdata[taplm_pkg::CHILD_W-1:0];
  assign rd_valid  = cv_rdata[taplm_pkg::CHILD_W];
  assign match     = rd_valid && (hop_rdata != '0);
  assign child_ok  = (rd_child != '0) &&
                     ({24'd0, rd_child} < 32'(taplm_pkg::NODE_COUNT));
  assign lvl_inc   = lvl_r + taplm_pkg::LEVEL_W'(1);
  assign walk_done = !child_ok ||
                     (({1'b0, lvl_r} + taplm_pkg::LEVEL_CNT_W'(1)) == levels_r);
  // during the walk, a held match goes out only when a deeper one shows up
  assign need_emit = match && pend_vld_r;
  assign walk_go   = !need_emit || out_free;
  assign out_load  = ((state_r == S_WALK) && walk_go && need_emit) ||
                     ((state_r == S_FIN) && out_free);

  always_comb begin
    cv_we    = 1'b0;
    cv_waddr = wr_addr;
    cv_wdata = {in_slot_valid, in_child_node};
    if (state_r == S_CLEAR) begin
      cv_we    = 1'b1;
      cv_waddr = clr_addr_r;
      cv_wdata = '0;
    end else if (wr_xfer && node_ok) begin
      cv_we = 1'b1;
    end
  end

  assign hop_we = wr_xfer && node_ok;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {taplm_pkg::NODE_AW'(0), in_addr_hi[63:56]};
    unique case (state_r)
      S_IDLE: begin
        rd_en = lk_xfer && (lv_cnt != '0);
      end
      S_WALK: begin
        rd_en   = walk_go && !walk_done;
        rd_addr = {taplm_pkg::NODE_AW'(rd_child),
                   taplm_pkg::addr_byte(addr_hi_r, addr_lo_r, lvl_inc)};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  taplm_ram #(
    .WIDTH(taplm_pkg::CHILD_W + 1),
    .DEPTH(taplm_pkg::STORE_DEPTH)
  ) u_cv_ram (
    .clk  (clk),
    .we   (cv_we),
    .waddr(cv_waddr),
    .wdata(cv_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(cv_rdata)
  );

  taplm_ram #(
    .WIDTH(taplm_pkg::HOP_W),
    .DEPTH(taplm_pkg::STORE_DEPTH)
  ) u_hop_ram (
    .clk  (clk),
    .we   (hop_we),
    .waddr(wr_addr),
    .wdata(in_slot_hop),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(hop_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      max_depth_r   <= taplm_pkg::MAX_DEPTH_RESET;
      default_hop_r <= '0;
      pend_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          taplm_pkg::CFG_MAX_DEPTH:   max_depth_r   <= cfg_data[7:0];
          taplm_pkg::CFG_DEFAULT_HOP: default_hop_r <= cfg_data;
          default:                    max_depth_r   <= max_depth_r;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + taplm_pkg::STORE_AW'(1);
          if (clr_addr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (lk_xfer) begin
            addr_hi_r  <= in_addr_hi;
            addr_lo_r  <= in_addr_lo;
            lvl_r      <= '0;
            levels_r   <= lv_cnt;
            pend_vld_r <= 1'b0;
            state_r    <= (lv_cnt == '0) ? S_FIN : S_WALK;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (need_emit) begin
              out_found_r        <= 1'b1;
              out_from_default_r <= 1'b0;
              out_match_level_r  <= pend_lvl_r;
              out_next_hop_r     <= pend_hop_r;
              out_last_r         <= 1'b0;
            end
            if (match) begin
              pend_vld_r <= 1'b1;
              pend_lvl_r <= lvl_r;
              pend_hop_r <= hop_rdata;
            end
            if (walk_done) begin
              state_r <= S_FIN;
            end else begin
              lvl_r <= lvl_inc;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            if (pend_vld_r) begin
              out_found_r        <= 1'b1;
              out_from_default_r <= 1'b0;
              out_match_level_r  <= pend_lvl_r;
              out_next_hop_r     <= pend_hop_r;
            end else begin
              out_found_r        <= (default_hop_r != '0);
              out_from_default_r <= (default_hop_r != '0);
              out_match_level_r  <= '0;
              out_next_hop_r     <= default_hop_r;
            end
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_from_default = out_from_default_r;
  assign out_match_level  = out_match_level_r;
  assign out_next_hop     = out_next_hop_r;
  assign out_last         = out_last_r;

  // no result may leave while the store is being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // a not-found result carries nothing
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      (out_next_hop_r == '0) && out_last_r && !out_from_default_r)
    else $error("malformed not-found result");

  // the default route is a lone final result at level zero
  a_default: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_from_default_r) |->
      out_found_r && out_last_r && (out_match_level_r == '0))
    else $error("malformed default result");

  // the walk never passes the level count
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ({1'b0, lvl_r} < levels_r))
    else $error("walk level out of range");

  // a held match only exists inside a lookup
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> ((state_r == S_WALK) || (state_r == S_FIN)))
    else $error("held match outside lookup");

endmodule

`default_nettype wire

// ----- sim/trie_lookup_checker.sv -----
// ----------------------------------------------------------------------------
// trie_lookup_checker
// Watches the request, result and register channels of the trie lookup core,
// keeps its own copy of the node store and registers, and predicts every
// route a lookup reports; each result transfer is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trie_lookup_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_node_sel,
  input  logic [7:0]  in_slot_sel,
  input  logic [7:0]  in_child_node,
  input  logic        in_slot_valid,
  input  logic [31:0] in_slot_hop,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic        out_from_default,
  input  logic [3:0]  out_match_level,
  input  logic [31:0] out_next_hop,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                          found;
    logic                          from_default;
    logic [taplm_pkg::LEVEL_W-1:0] level;
    logic [taplm_pkg::HOP_W-1:0]   hop;
    logic                          last;
  } route_t;

  logic [taplm_pkg::CHILD_W-1:0] child_mem [taplm_pkg::STORE_DEPTH];
  logic                          valid_mem [taplm_pkg::STORE_DEPTH];
  logic [taplm_pkg::HOP_W-1:0]   hop_mem   [taplm_pkg::STORE_DEPTH];
  logic [7:0]                    depth_bits;
  logic [taplm_pkg::HOP_W-1:0]   dflt_nh;
  route_t                        route_q [$];
  int                            errors;

  function automatic logic [7:0] addr_octet(input logic [63:0] hi, input logic [63:0] lo,
                                            input int lvl);
    logic [63:0] word;
    word = (lvl < 8) ? hi : lo;
    return word[63 - 8 * (lvl % 8) -: 8];
  endfunction

  // walk the trie and queue every route the lookup should report, shallowest first
  function automatic void predict_routes(input logic [63:0] hi, input logic [63:0] lo);
    route_t                         hits [taplm_pkg::MAX_LEVELS];
    int                             n_hits;
    int                             levels;
    logic [taplm_pkg::NODE_AW-1:0]  node;
    logic [taplm_pkg::STORE_AW-1:0] idx;
    levels = (int'(depth_bits) + taplm_pkg::STRIDE_BITS - 1) / taplm_pkg::STRIDE_BITS;
    if (levels > taplm_pkg::MAX_LEVELS) levels = taplm_pkg::MAX_LEVELS;
    n_hits = 0;
    node = '0;
    for (int lvl = 0; lvl < levels; lvl++) begin
      idx = {node, addr_octet(hi, lo, lvl)};
      if (valid_mem[idx] && hop_mem[idx] != '0) begin
        hits[n_hits] = '{1'b1, 1'b0, taplm_pkg::LEVEL_W'(lvl), hop_mem[idx], 1'b0};
        n_hits++;
      end
      if (child_mem[idx] == '0 || int'(child_mem[idx]) >= taplm_pkg::NODE_COUNT) break;
      node = taplm_pkg::NODE_AW'(child_mem[idx]);
    end
    if (n_hits == 0) begin
      if (dflt_nh != '0) begin
        hits[0] = '{1'b1, 1'b1, '0, dflt_nh, 1'b1};
      end else begin
        hits[0] = '{1'b0, 1'b0, '0, '0, 1'b1};
      end
      n_hits = 1;
    end
    hits[n_hits - 1].last = 1'b1;
    for (int k = 0; k < n_hits; k++) route_q.push_back(hits[k]);
  endfunction

  function automatic int field_mismatch(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    route_t                         got;
    route_t                         want;
    logic [taplm_pkg::STORE_AW-1:0] idx;
    if (!rst_n) begin
      for (int i = 0; i < taplm_pkg::STORE_DEPTH; i++) begin
        child_mem[i] = '0;
        valid_mem[i] = 1'b0;
        hop_mem[i]   = '0;
      end
      route_q.delete();
      depth_bits = taplm_pkg::MAX_DEPTH_RESET;
      dflt_nh    = '0;
      errors     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_found, out_from_default, out_match_level, out_next_hop, out_last};
        if (route_q.size() == 0) begin
          $error("result transfer with no lookup outstanding: hop %0h level %0d",
                 out_next_hop, out_match_level);
          errors++;
        end else begin
          want = route_q.pop_front();
          errors += field_mismatch("found", 32'(want.found), 32'(got.found));
          errors += field_mismatch("from_default", 32'(want.from_default),
                                   32'(got.from_default));
          errors += field_mismatch("match_level", 32'(want.level), 32'(got.level));
          errors += field_mismatch("next_hop", want.hop, got.hop);
          errors += field_mismatch("last", 32'(want.last), 32'(got.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == taplm_pkg::CFG_MAX_DEPTH) depth_bits = cfg_data[7:0];
        else dflt_nh = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == taplm_pkg::REQ_WRITE) begin
          if (int'(in_node_sel) < taplm_pkg::NODE_COUNT) begin
            idx = {in_node_sel[taplm_pkg::NODE_AW-1:0], in_slot_sel};
            child_mem[idx] = in_child_node;
            valid_mem[idx] = in_slot_valid;
            hop_mem[idx]   = in_slot_hop;
          end
        end else begin
          predict_routes(in_addr_hi, in_addr_lo);
        end
      end
    end
    fail_count <= errors;
    pending    <= route_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Builds trie paths and looks them up, whole and altered, under several depth
// and default-route settings with random gaps and result stalls; the checker
// beside the core predicts and compares every route reported.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // the limit must cover the clearing pass after reset, which runs without a transfer
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int PHASE_ITEMS    = 18;
  localparam int SETTLE_CYCLES  = 24;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [63:0] in_addr_hi;
  logic [63:0] in_addr_lo;
  logic [7:0]  in_node_sel;
  logic [7:0]  in_slot_sel;
  logic [7:0]  in_child_node;
  logic        in_slot_valid;
  logic [31:0] in_slot_hop;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic        out_from_default;
  logic [3:0]  out_match_level;
  logic [31:0] out_next_hop;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;

  int            items_sent;
  int            stuck_cycles;
  bit            quiet;
  logic [7:0]    next_free;
  logic [127:0]  known_q [$];

  trie_all_prefix_match_lookup_core dut (.*);

  trie_lookup_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: before each transfer, stall for a drawn number of cycles, zero during calm spells
  initial begin
    int hold;
    bit calm;
    out_stall = 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [127:0] random_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic drive_item(input taplm_pkg::req_type_t kind, input logic [63:0] hi,
                            input logic [63:0] lo, input logic [7:0] node,
                            input logic [7:0] slot, input logic [7:0] child,
                            input logic valid, input logic [31:0] hop);
    int gap;
    if ($urandom_range(0, 19) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_addr_hi    <= hi;
    in_addr_lo    <= lo;
    in_node_sel   <= node;
    in_slot_sel   <= slot;
    in_child_node <= child;
    in_slot_valid <= valid;
    in_slot_hop   <= hop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic lookup(input logic [127:0] a);
    drive_item(taplm_pkg::REQ_LOOKUP, a[127:64], a[63:0], 8'($urandom), 8'($urandom),
               8'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic write_slot(input logic [7:0] node, input logic [7:0] slot,
                            input logic [7:0] child, input logic valid,
                            input logic [31:0] hop);
    drive_item(taplm_pkg::REQ_WRITE, {$urandom, $urandom}, {$urandom, $urandom}, node,
               slot, child, valid, hop);
  endtask

  // lay a chain of fresh nodes along the address, one slot per level
  task automatic add_route(input logic [127:0] a, input int depth);
    logic [7:0] node;
    logic [7:0] child;
    node = 8'd0;
    for (int lvl = 0; lvl < depth; lvl++) begin
      if (lvl == depth - 1) begin
        child = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
      end else begin
        next_free = (next_free == 8'd255) ? 8'd1 : next_free + 8'd1;
        child = next_free;
      end
      write_slot(node, a[127 - 8 * lvl -: 8], child, $urandom_range(0, 3) != 0,
                 ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
      node = child;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input taplm_pkg::cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase();
    int           start;
    int           pick;
    int           flip;
    logic [127:0] a;
    start = items_sent;
    lookup('1);
    lookup('0);
    lookup(random_addr());
    while (items_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        a = random_addr();
        add_route(a, ($urandom_range(0, 5) == 0) ? int'($urandom_range(6, 16))
                                                  : int'($urandom_range(1, 5)));
        lookup(a);
        known_q.push_back(a);
        if (known_q.size() > 32) void'(known_q.pop_front());
      end else if (pick < 7 && known_q.size() > 0) begin
        // revisit a known route, sometimes with one byte changed
        a = known_q[$urandom_range(0, known_q.size() - 1)];
        if ($urandom_range(0, 1) == 1) begin
          flip = $urandom_range(0, 15);
          a[127 - 8 * flip -: 8] = a[127 - 8 * flip -: 8] ^ 8'($urandom_range(1, 255));
        end
        lookup(a);
      end else if (pick < 9) begin
        write_slot(($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                   8'($urandom), 8'($urandom), 1'($urandom), $urandom);
      end else begin
        lookup(random_addr());
      end
    end
  endtask

  initial begin
    logic [7:0]  depth;
    logic [31:0] dflt;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = taplm_pkg::REQ_LOOKUP;
    in_addr_hi    = '0;
    in_addr_lo    = '0;
    in_node_sel   = '0;
    in_slot_sel   = '0;
    in_child_node = '0;
    in_slot_valid = 1'b0;
    in_slot_hop   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = taplm_pkg::CFG_MAX_DEPTH;
    cfg_data      = '0;
    items_sent    = 0;
    stuck_cycles  = 0;
    quiet         = 1'b0;
    next_free     = 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty trie: not found
    lookup('0);
    // all-ones path loops on node 255, so every level matches
    write_slot(8'd0, 8'hFF, 8'd255, 1'b1, 32'hFFFF_FFFF);
    write_slot(8'd255, 8'hFF, 8'd255, 1'b1, 32'h8000_0001);
    lookup('1);
    // valid slot with a zero hop reports nothing
    write_slot(8'd255, 8'h00, 8'd0, 1'b1, 32'd0);
    lookup({8'hFF, 120'd0});
    // hop present but slot not valid
    write_slot(8'd0, 8'h01, 8'd0, 1'b0, 32'd5);
    lookup({8'h01, 120'd0});
    // match only below the root
    write_slot(8'd0, 8'h00, 8'd1, 1'b0, 32'd0);
    write_slot(8'd1, 8'h00, 8'd0, 1'b1, 32'd1);
    lookup('0);
    write_slot(8'd0, 8'h80, 8'd0, 1'b1, 32'hA5A5_A5A5);
    lookup({8'h80, {15{8'h5A}}});
    next_free = 8'd1;
    random_phase();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          depth = 8'd128;
          dflt  = 32'hFFFF_FFFF;
        end
        1: begin
          depth = 8'd8;
          dflt  = $urandom;
        end
        2: begin
          depth = 8'd0;
          dflt  = 32'd0;
        end
        3: begin
          depth = 8'd255;
          dflt  = 32'd1;
        end
        default: begin
          depth = 8'($urandom_range(1, 255));
          dflt  = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
        end
      endcase
      wait_idle();
      set_config(taplm_pkg::CFG_MAX_DEPTH, {24'($urandom), depth});
      set_config(taplm_pkg::CFG_DEFAULT_HOP, dflt);
      random_phase();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
